// ===== rtl/vpsdc_pkg.sv =====
// Shared types and constants for the vector pair sum, dot and cosine block.
`timescale 1ns / 1ps
package vpsdc_pkg;

  localparam int MaxLen = 16;
  localparam int CntW = 7;
  localparam int DotW = 36;
  localparam int SqW = 35;
  localparam int RootW = 18;
  localparam int CosW = 16;
  localparam logic signed [DotW-1:0] DotMax = {1'b0, {(DotW-1){1'b1}}};
  localparam logic signed [DotW-1:0] DotMin = {1'b1, {(DotW-1){1'b0}}};
  localparam logic [SqW-1:0] SqMax = {SqW{1'b1}};
  localparam int SqrtSteps = 18;
  localparam int DivW = 51;
  localparam int QuoW = 51;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SQRT,
    ST_DEN,
    ST_DIV,
    ST_OUT
  } vpsdc_state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic sqrt_start;
    logic sqrt_step;
    logic den;
    logic div_start;
    logic div_step;
    logic finish;
  } vpsdc_cmd_t;

  typedef struct packed {
    logic is_last;
    logic sqrt_done;
    logic div_done;
    logic zero_norm;
  } vpsdc_stat_t;

endpackage

// ===== rtl/vpsdc_ctrl.sv =====
// Controller state machine sequencing accumulate, root and divide steps.
`timescale 1ns / 1ps
module vpsdc_ctrl import vpsdc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output vpsdc_cmd_t  cmd,
  input  vpsdc_stat_t stat
);

  vpsdc_state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC:  state_next = stat.is_last ? ST_SQRT : ST_OUT;
      ST_SQRT: if (stat.sqrt_done) state_next = ST_DEN;
      ST_DEN:  state_next = stat.zero_norm ? ST_OUT : ST_DIV;
      ST_DIV:  if (stat.div_done) state_next = ST_OUT;
      ST_OUT:  if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.sqrt_start = stat.is_last;
      end
      ST_SQRT: cmd.sqrt_step = 1'b1;
      ST_DEN: begin
        cmd.den = 1'b1;
        cmd.div_start = !stat.zero_norm;
      end
      ST_DIV: cmd.div_step = 1'b1;
      ST_OUT: begin
        out_valid = 1'b1;
        cmd.finish = !out_stall;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/vpsdc_dp.sv =====
// Datapath: products, saturating accumulators, two-lane root unit and divide unit.
`timescale 1ns / 1ps
module vpsdc_dp import vpsdc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [15:0]      elem_a,
  input  logic signed [15:0]      elem_b,
  input  logic                    last,
  input  vpsdc_cmd_t              cmd,
  output vpsdc_stat_t             stat,
  output logic signed [16:0]      elem_sum,
  output logic signed [16:0]      elem_diff,
  output logic                    done_res,
  output logic signed [DotW-1:0]  dot,
  output logic [RootW-1:0]        norm_a,
  output logic [RootW-1:0]        norm_b,
  output logic signed [CosW-1:0]  cosine,
  output logic                    zero_norm,
  output logic                    over_length
);

  logic signed [15:0] a_reg, b_reg;
  logic last_reg;
  logic signed [31:0] p_ab;
  logic [31:0] p_aa, p_bb;
  logic [CntW-1:0] elem_count;
  logic signed [DotW-1:0] dot_acc;
  logic [SqW-1:0] sq_a, sq_b;
  logic length_error;
  logic signed [DotW+1:0] dot_sum;
  logic [SqW:0] sa_sum, sb_sum;
  logic acc_en;
  logic [SqW-1:0] sq_a_next, sq_b_next;
  // root units: remainder and scaled root, two lanes
  logic [SqW+1:0] rem_a, rem_b;
  logic [SqW+1:0] rt_a, rt_b;
  logic [4:0] sq_cnt;
  logic [SqW+1:0] bit_q;
  logic [SqW+1:0] try_a, try_b;
  logic [RootW-1:0] na, nb;
  logic [2*RootW-1:0] den;
  // divider
  logic neg;
  logic [DivW-1:0] num_mag, rem_d;
  logic [QuoW-1:0] quo;
  logic [5:0] div_cnt;
  logic [DivW:0] rem_sh;
  logic [QuoW-1:0] cos_mag;

  // Capture request, then form products, sum and difference
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg <= elem_a;
      b_reg <= elem_b;
      last_reg <= last;
    end
    if (cmd.mul) begin
      p_ab <= a_reg * b_reg;
      p_aa <= 32'(a_reg * a_reg);
      p_bb <= 32'(b_reg * b_reg);
      elem_sum <= 17'(a_reg) + 17'(b_reg);
      elem_diff <= 17'(a_reg) - 17'(b_reg);
    end
  end

  assign dot_sum = (DotW+2)'(dot_acc) + (DotW+2)'(p_ab);
  assign sa_sum = (SqW+1)'(sq_a) + (SqW+1)'(p_aa);
  assign sb_sum = (SqW+1)'(sq_b) + (SqW+1)'(p_bb);
  assign acc_en = (elem_count < CntW'(MaxLen));
  assign sq_a_next = sa_sum[SqW] ? SqMax : sa_sum[SqW-1:0];
  assign sq_b_next = sb_sum[SqW] ? SqMax : sb_sum[SqW-1:0];

  // Accumulate with saturation; clear after a last request
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      dot_acc <= '0;
      sq_a <= '0;
      sq_b <= '0;
      length_error <= 1'b0;
    end else if (cmd.finish && done_res) begin
      elem_count <= '0;
      dot_acc <= '0;
      sq_a <= '0;
      sq_b <= '0;
      length_error <= 1'b0;
    end else if (cmd.acc) begin
      if (acc_en) begin
        if (dot_sum > (DotW+2)'(DotMax)) dot_acc <= DotMax;
        else if (dot_sum < (DotW+2)'(DotMin)) dot_acc <= DotMin;
        else dot_acc <= dot_sum[DotW-1:0];
        sq_a <= sq_a_next;
        sq_b <= sq_b_next;
        elem_count <= elem_count + 1'b1;
      end else begin
        length_error <= 1'b1;
      end
    end
  end

  // Root step: one result bit per cycle per lane; start from the updated sums
  assign try_a = rem_a - (rt_a + bit_q);
  assign try_b = rem_b - (rt_b + bit_q);
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      rem_a <= (SqW+2)'(acc_en ? sq_a_next : sq_a);
      rem_b <= (SqW+2)'(acc_en ? sq_b_next : sq_b);
      rt_a <= '0;
      rt_b <= '0;
      bit_q <= (SqW+2)'(1) << (2*(SqrtSteps-1));
      sq_cnt <= '0;
    end else if (cmd.sqrt_step && sq_cnt != 5'(SqrtSteps)) begin
      if (rem_a >= rt_a + bit_q) begin
        rem_a <= try_a;
        rt_a <= (rt_a >> 1) + bit_q;
      end else rt_a <= rt_a >> 1;
      if (rem_b >= rt_b + bit_q) begin
        rem_b <= try_b;
        rt_b <= (rt_b >> 1) + bit_q;
      end else rt_b <= rt_b >> 1;
      bit_q <= bit_q >> 2;
      sq_cnt <= sq_cnt + 1'b1;
    end
  end
  assign na = rt_a[RootW-1:0];
  assign nb = rt_b[RootW-1:0];
  assign stat.sqrt_done = (sq_cnt == 5'(SqrtSteps));
  assign stat.zero_norm = (na == '0) || (nb == '0);
  assign stat.is_last = last_reg;

  // Denominator, then restoring divide one bit per cycle
  assign rem_sh = {rem_d, num_mag[DivW-1]};
  always_ff @(posedge clk) begin
    if (cmd.den) den <= na * nb;
    if (cmd.div_start) begin
      neg <= dot_acc[DotW-1];
      num_mag <= (dot_acc[DotW-1] ? -DivW'(dot_acc) : DivW'(dot_acc)) << 14;
      rem_d <= '0;
      quo <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step && div_cnt != 6'(DivW)) begin
      num_mag <= num_mag << 1;
      if (rem_sh >= (DivW+1)'(den)) begin
        rem_d <= DivW'(rem_sh - (DivW+1)'(den));
        quo <= {quo[QuoW-2:0], 1'b1};
      end else begin
        rem_d <= rem_sh[DivW-1:0];
        quo <= {quo[QuoW-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
    end
  end
  assign stat.div_done = (div_cnt == 6'(DivW));

  // Clamp and sign the quotient
  assign cos_mag = (quo > QuoW'(16384)) ? QuoW'(16384) : quo;
  always_comb begin
    done_res = last_reg;
    dot = '0;
    norm_a = '0;
    norm_b = '0;
    cosine = '0;
    zero_norm = 1'b0;
    over_length = 1'b0;
    if (last_reg) begin
      dot = dot_acc;
      norm_a = na;
      norm_b = nb;
      zero_norm = stat.zero_norm;
      over_length = length_error;
      if (!stat.zero_norm)
        cosine = neg ? -CosW'(cos_mag) : CosW'(cos_mag);
    end
  end

endmodule

// ===== rtl/vector_pair_sum_dot_cosine.sv =====
// Top level of the vector pair sum, dot product and cosine block.
// Usage:
//   Input channel in_valid/in_stall carries one coordinate pair elem_a,
//   elem_b (signed Q8.8) and last. Output channel out_valid/out_stall
//   returns one result per request: sum, difference, and on the last
//   coordinate the dot product, both floor-root norms and Q1.14 cosine.
// Sequence:
//   A plain coordinate is multiplied, then accumulated, and its result is
//   then offered; once it is delivered, the block returns to idle and
//   the next request can be taken.
//   A last coordinate adds root iteration (one root bit per cycle, both
//   norms in parallel), the norm product and restoring division (one
//   quotient bit per cycle) unless a norm is zero. One request is in
//   flight at a time.
// Reset: rst clears the state machine, the element counter and the accumulators.
// Stall: the result holds on the output ports while out_stall is high and
//   no new request is taken until it is delivered.
`timescale 1ns / 1ps
module vector_pair_sum_dot_cosine import vpsdc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [15:0]     elem_a,
  input  logic signed [15:0]     elem_b,
  input  logic                   last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [16:0]     elem_sum,
  output logic signed [16:0]     elem_diff,
  output logic                   done_res,
  output logic signed [DotW-1:0] dot,
  output logic [RootW-1:0]       norm_a,
  output logic [RootW-1:0]       norm_b,
  output logic signed [CosW-1:0] cosine,
  output logic                   zero_norm,
  output logic                   over_length
);

  vpsdc_cmd_t  cmd;
  vpsdc_stat_t stat;

  vpsdc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  vpsdc_dp u_dp (
    .clk, .rst, .elem_a, .elem_b, .last, .cmd, .stat, .elem_sum, .elem_diff,
    .done_res, .dot, .norm_a, .norm_b, .cosine, .zero_norm, .over_length
  );

endmodule

// ===== rtl/vpsdc_checker.sv =====
// Port-level checker for the vector pair block, bound to the top level.
`timescale 1ns / 1ps
module vpsdc_checker import vpsdc_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic                   done_res,
  input logic signed [CosW-1:0] cosine,
  input logic                   zero_norm
);

  // One request in flight: no accept while a result is shown
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("accept during result");

  // Cosine stays within plus or minus one
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cosine <= 16'sd16384 && cosine >= -16'sd16384))
    else $error("cosine out of range");

  // Zero norm forces zero cosine
  a_zero_cos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_norm) |-> (cosine == '0)) else $error("cosine not zero");

  // Totals flags only on a last result
  a_flags_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (!zero_norm && cosine == '0))
    else $error("totals on non-last");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cosine)))
    else $error("result dropped");

endmodule

bind vector_pair_sum_dot_cosine vpsdc_checker u_vpsdc_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .done_res,
  .cosine, .zero_norm
);

// ===== sim/vector_pair_sum_dot_cosine_tb.sv =====
// Self-checking testbench for the vector pair sum, dot product and cosine block.
`timescale 1ns / 1ps
module vector_pair_sum_dot_cosine_tb;
  import vpsdc_pkg::*;

  typedef struct {
    logic signed [16:0]     sum;
    logic signed [16:0]     diff;
    logic                   done;
    logic signed [DotW-1:0] dotp;
    logic [RootW-1:0]       na;
    logic [RootW-1:0]       nb;
    logic signed [CosW-1:0] cosv;
    logic                   zn;
    logic                   ovl;
  } pair_res_t;

  typedef struct {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic               lst;
    logic               known;
    pair_res_t          res;
  } stim_row_t;

  localparam int WatchLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] elem_a = '0;
  logic signed [15:0] elem_b = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [16:0] elem_sum, elem_diff;
  logic done_res, zero_norm, over_length;
  logic signed [DotW-1:0] dot;
  logic [RootW-1:0] norm_a, norm_b;
  logic signed [CosW-1:0] cosine;

  vector_pair_sum_dot_cosine i_dut (
    .clk, .rst, .in_valid, .in_stall, .elem_a, .elem_b, .last,
    .out_valid, .out_stall, .elem_sum, .elem_diff, .done_res, .dot,
    .norm_a, .norm_b, .cosine, .zero_norm, .over_length
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  int unsigned       pr_count;
  longint            pr_dot;
  longint unsigned   pr_sqa, pr_sqb;
  bit                pr_err;
  pair_res_t         expected_q[$];
  int                fail_cnt = 0;
  int                send_idle = 0, recv_idle = 0;
  bit                hold_off = 0;
  int                quiet = 0;
  int                sent = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Advance the pair accumulators by one coordinate and form its result.
  function automatic pair_res_t predict_pair(logic signed [15:0] a, logic signed [15:0] b,
                                             logic lst);
    pair_res_t r;
    longint sa, sb, d, q;
    longint unsigned ra, rb;
    sa = a;
    sb = b;
    r = '{default: '0};
    r.sum = 17'(sa + sb);
    r.diff = 17'(sa - sb);
    if (pr_count < MaxLen) begin
      d = pr_dot + sa * sb;
      if (d > 64'sd34359738367) d = 64'sd34359738367;
      if (d < -64'sd34359738368) d = -64'sd34359738368;
      pr_dot = d;
      pr_sqa = pr_sqa + longint'(sa * sa);
      if (pr_sqa > 64'd34359738367) pr_sqa = 64'd34359738367;
      pr_sqb = pr_sqb + longint'(sb * sb);
      if (pr_sqb > 64'd34359738367) pr_sqb = 64'd34359738367;
      pr_count++;
    end else begin
      pr_err = 1;
    end
    if (lst) begin
      ra = isqrt(pr_sqa);
      rb = isqrt(pr_sqb);
      q = 0;
      r.zn = (ra == 0) || (rb == 0);
      if (!r.zn) begin
        q = (pr_dot * 16384) / longint'(ra * rb);
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
      end
      r.done = 1;
      r.dotp = DotW'(pr_dot);
      r.na = RootW'(ra);
      r.nb = RootW'(rb);
      r.cosv = CosW'(q);
      r.ovl = pr_err;
      pr_count = 0; pr_dot = 0; pr_sqa = 0; pr_sqb = 0; pr_err = 0;
    end
    return r;
  endfunction

  // Offer one request and hold it until accepted.
  task automatic send_pair(logic signed [15:0] a, logic signed [15:0] b, logic lst,
                           bit known, pair_res_t kr);
    pair_res_t r;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    r = predict_pair(a, b, lst);
    if (known) r = kr;
    expected_q.push_back(r);
    elem_a <= a;
    elem_b <= b;
    last <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Check each delivered result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      pair_res_t e;
      if (expected_q.size() == 0) begin
        $error("result with no expectation: sum %0d", elem_sum);
        fail_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (elem_sum !== e.sum) begin
          $error("elem_sum exp %0d got %0d", e.sum, elem_sum); fail_cnt++;
        end
        if (elem_diff !== e.diff) begin
          $error("elem_diff exp %0d got %0d", e.diff, elem_diff); fail_cnt++;
        end
        if (done_res !== e.done) begin
          $error("done_res exp %0d got %0d", e.done, done_res); fail_cnt++;
        end
        if (dot !== e.dotp) begin
          $error("dot exp %0d got %0d", e.dotp, dot); fail_cnt++;
        end
        if (norm_a !== e.na) begin
          $error("norm_a exp %0d got %0d", e.na, norm_a); fail_cnt++;
        end
        if (norm_b !== e.nb) begin
          $error("norm_b exp %0d got %0d", e.nb, norm_b); fail_cnt++;
        end
        if (cosine !== e.cosv) begin
          $error("cosine exp %0d got %0d", e.cosv, cosine); fail_cnt++;
        end
        if (zero_norm !== e.zn) begin
          $error("zero_norm exp %0d got %0d", e.zn, zero_norm); fail_cnt++;
        end
        if (over_length !== e.ovl) begin
          $error("over_length exp %0d got %0d", e.ovl, over_length); fail_cnt++;
        end
      end
    end
  end

  // Drive the receiver stall: random idling, or a long hold-off on request.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle);
  end

  // Count cycles with no accepted request on either side.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering.
  task automatic press_hold();
    int n;
    hold_off = 1;
    n = 0;
    while (n < 300) begin
      @(posedge clk);
      n++;
    end
    hold_off = 0;
  endtask

  // Send a random pair vector; lengths mostly legal, some over-length.
  task automatic random_vector();
    int len, k, mode;
    logic signed [15:0] a, b;
    len = ($urandom_range(9) == 0) ? $urandom_range(MaxLen + 6, MaxLen + 1)
                                   : $urandom_range(MaxLen, 1);
    mode = $urandom_range(5);
    for (k = 0; k < len; k++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      if (mode == 0) b = a;
      if (mode == 1) b = -a;
      if (mode == 2) a = 0;
      if (mode == 3) begin
        a = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        b = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
      send_pair(a, b, k == len - 1, 0, '{default: '0});
    end
  endtask

  stim_row_t table_rows[$];

  function automatic pair_res_t plain_res(int s, int d);
    pair_res_t r;
    r = '{default: '0};
    r.sum = 17'(s);
    r.diff = 17'(d);
    return r;
  endfunction

  function automatic stim_row_t row(logic signed [15:0] a, logic signed [15:0] b,
                                    logic lst, bit known, pair_res_t r);
    stim_row_t t;
    t.a = a; t.b = b; t.lst = lst; t.known = known; t.res = r;
    return t;
  endfunction

  initial begin
    pair_res_t r;
    int ph, k;
    // directed rows: extremes, zero norm, equal and opposite, over-length
    r = plain_res(0, 0); r.done = 1; r.zn = 1;
    table_rows.push_back(row(0, 0, 1, 1, r));
    table_rows.push_back(row(16'sh7fff, 16'sh7fff, 0, 1, plain_res(65534, 0)));
    table_rows.push_back(row(16'sh8000, 16'sh8000, 0, 1, plain_res(-65536, 0)));
    table_rows.push_back(row(16'sh7fff, 16'sh8000, 1, 0, r));
    table_rows.push_back(row(16'sh8000, 16'sh7fff, 1, 1, plain_res(-1, -65535)));
    table_rows[4].res.done = 1;
    table_rows[4].res.dotp = -36'sd1073709056;
    table_rows[4].res.na = 32768;
    table_rows[4].res.nb = 32767;
    table_rows[4].res.cosv = -16384;
    table_rows.push_back(row(256, 0, 1, 0, r));
    table_rows.push_back(row(256, 256, 0, 0, r));
    table_rows.push_back(row(-512, -512, 1, 0, r));
    table_rows.push_back(row(300, -300, 1, 0, r));
    table_rows.push_back(row(-1, 1, 1, 0, r));
    for (k = 0; k < MaxLen + 3; k++)
      table_rows.push_back(row(16'(k * 37 - 300), 16'(500 - k * 11), k == MaxLen + 2, 0, r));

    pr_count = 0; pr_dot = 0; pr_sqa = 0; pr_sqb = 0; pr_err = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (table_rows[i]) begin
      send_pair(table_rows[i].a, table_rows[i].b, table_rows[i].lst,
                table_rows[i].known, table_rows[i].res);
    end

    for (ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 17 : (ph == 1) ? 74 : 0;
      recv_idle = (ph == 0) ? 74 : (ph == 1) ? 17 : 0;
      sent = 0;
      if (ph == 2) fork press_hold(); join_none
      while (sent < 205) begin
        random_vector();
      end
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
